### rtl/core/xcfp_pkg.sv
package xcfp_pkg;

  // Frame geometry
  localparam int MaxFrameBytes = 64;
  localparam int FrameOverhead = 5;
  localparam int HeadKeep      = 5;
  localparam int GestureNeed   = 5;
  // Wide enough for the largest length byte plus the frame overhead
  localparam int CountW        = $clog2(256 + FrameOverhead);

  // Configuration register map
  localparam int CfgIndexW = 3;
  typedef enum logic [CfgIndexW-1:0] {
    REG_HEADER_FIRST  = 3'd0,
    REG_HEADER_SECOND = 3'd1,
    REG_CODE_GESTURE  = 3'd2,
    REG_CODE_POSTURE  = 3'd3,
    REG_CODE_EMOTION  = 3'd4,
    REG_CODE_POMODORO = 3'd5,
    REG_CODE_SENTRY   = 3'd6
  } reg_index_t;

  // Reset values of the configuration registers
  localparam logic [7:0] ResetHeaderFirst  = 8'd170;
  localparam logic [7:0] ResetHeaderSecond = 8'd85;
  localparam logic [7:0] ResetCodeGesture  = 8'd1;
  localparam logic [7:0] ResetCodePosture  = 8'd2;
  localparam logic [7:0] ResetCodeEmotion  = 8'd3;
  localparam logic [7:0] ResetCodePomodoro = 8'd4;
  localparam logic [7:0] ResetCodeSentry   = 8'd5;

  // Parser phases
  typedef enum logic [2:0] {
    PH_HEAD1,
    PH_HEAD2,
    PH_LEN,
    PH_CMD,
    PH_BODY
  } phase_t;

  // Stored record
  typedef struct packed {
    logic [7:0]  gesture_num;
    logic [15:0] hand_x;
    logic [15:0] hand_y;
    logic [7:0]  posture;
    logic [7:0]  emotion;
    logic [7:0]  focus_phase;
    logic [7:0]  guard_level;
    logic        valid;
  } record_t;

  // One result transaction
  typedef struct packed {
    logic [7:0] command;
    record_t    rec;
  } result_t;

endpackage

### rtl/core/xor_checked_frame_parser.sv
// A good frame's checksum byte loads its result into the output register when it
// is accepted, if that register is free or being read; the result is offered from
// the next cycle. Throughput: one byte per cycle; the running XOR and the payload
// position update in the same cycle. A skid register keeps bytes flowing while one
// result waits; input stalls only while output and skid registers both hold results.
// Reset (rst, synchronous): hunt for the first header, clear the record, load defaults.
module xor_checked_frame_parser (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      rx_byte,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [xcfp_pkg::CfgIndexW-1:0]  cfg_index,
  input  logic [7:0]                      cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      command,
  output logic [7:0]                      gesture_num,
  output logic [15:0]                     hand_x,
  output logic [15:0]                     hand_y,
  output logic [7:0]                      posture,
  output logic [7:0]                      emotion,
  output logic [7:0]                      focus_phase,
  output logic [7:0]                      guard_level,
  output logic                            record_valid
);
  import xcfp_pkg::*;

  // Configuration registers
  logic [7:0] header_first;
  logic [7:0] header_second;
  logic [7:0] code_gesture;
  logic [7:0] code_posture;
  logic [7:0] code_emotion;
  logic [7:0] code_pomodoro;
  logic [7:0] code_sentry;

  // Parser state
  phase_t     phase, phase_next;
  logic [7:0] payload_length;
  logic [7:0] frame_command;
  logic [7:0] running_xor, running_xor_next;
  logic [7:0] pay_pos, pay_pos_next;
  logic [7:0] payload_head [HeadKeep];
  record_t    rec, rec_next;

  // Output register and skid register
  result_t    out_reg;
  logic       skid_valid;
  result_t    skid_reg;

  logic       in_fire;
  logic       out_fire;
  logic       frame_good;
  logic       produce;
  logic [CountW-1:0] len_total;
  result_t    result;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign produce   = in_fire && frame_good;
  assign len_total = CountW'(rx_byte) + CountW'(FrameOverhead);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= ResetHeaderFirst;
      header_second <= ResetHeaderSecond;
      code_gesture  <= ResetCodeGesture;
      code_posture  <= ResetCodePosture;
      code_emotion  <= ResetCodeEmotion;
      code_pomodoro <= ResetCodePomodoro;
      code_sentry   <= ResetCodeSentry;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HEADER_FIRST:  header_first  <= cfg_data;
        REG_HEADER_SECOND: header_second <= cfg_data;
        REG_CODE_GESTURE:  code_gesture  <= cfg_data;
        REG_CODE_POSTURE:  code_posture  <= cfg_data;
        REG_CODE_EMOTION:  code_emotion  <= cfg_data;
        REG_CODE_POMODORO: code_pomodoro <= cfg_data;
        REG_CODE_SENTRY:   code_sentry   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next phase, running XOR and payload position
  always_comb begin
    phase_next       = phase;
    running_xor_next = running_xor;
    pay_pos_next     = pay_pos;
    frame_good       = 1'b0;
    case (phase)
      PH_HEAD1: begin
        if (rx_byte == header_first) begin
          running_xor_next = rx_byte;
          phase_next       = PH_HEAD2;
        end
      end
      PH_HEAD2: begin
        if (rx_byte == header_second) begin
          running_xor_next = running_xor ^ rx_byte;
          phase_next       = PH_LEN;
        end else begin
          phase_next = PH_HEAD1;
        end
      end
      PH_LEN: begin
        // Drop frames that do not fit
        if (len_total > CountW'(MaxFrameBytes)) begin
          phase_next = PH_HEAD1;
        end else begin
          running_xor_next = running_xor ^ rx_byte;
          phase_next       = PH_CMD;
        end
      end
      PH_CMD: begin
        running_xor_next = running_xor ^ rx_byte;
        pay_pos_next     = '0;
        phase_next       = PH_BODY;
      end
      PH_BODY: begin
        if (pay_pos < payload_length) begin
          running_xor_next = running_xor ^ rx_byte;
          pay_pos_next     = pay_pos + 8'd1;
        end else begin
          // Checksum byte closes the frame
          frame_good = (rx_byte == running_xor);
          phase_next = PH_HEAD1;
        end
      end
      default: phase_next = PH_HEAD1;
    endcase
  end

  // Record update for a good frame, first matching code wins
  always_comb begin
    rec_next = rec;
    if (frame_command == code_gesture) begin
      if (payload_length >= 8'(GestureNeed)) begin
        rec_next.gesture_num = payload_head[0];
        rec_next.hand_x      = {payload_head[2], payload_head[1]};
        rec_next.hand_y      = {payload_head[4], payload_head[3]};
        rec_next.valid       = 1'b1;
      end
    end else if (frame_command == code_posture) begin
      if (payload_length != 8'd0) begin
        rec_next.posture = payload_head[0];
        rec_next.valid   = 1'b1;
      end
    end else if (frame_command == code_emotion) begin
      if (payload_length != 8'd0) begin
        rec_next.emotion = payload_head[0];
        rec_next.valid   = 1'b1;
      end
    end else if (frame_command == code_pomodoro) begin
      if (payload_length != 8'd0) begin
        rec_next.focus_phase = payload_head[0];
      end
    end else if (frame_command == code_sentry) begin
      if (payload_length != 8'd0) begin
        rec_next.guard_level = payload_head[0];
        rec_next.valid       = 1'b1;
      end
    end
    result.command = frame_command;
    result.rec     = rec_next;
  end

  // Phase register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEAD1;
    end else if (in_fire) begin
      phase <= phase_next;
    end
  end

  // Frame fields and running checksum
  always_ff @(posedge clk) begin
    if (in_fire) begin
      running_xor <= running_xor_next;
      pay_pos     <= pay_pos_next;
      if (phase == PH_LEN) begin
        payload_length <= rx_byte;
      end
      if (phase == PH_CMD) begin
        frame_command <= rx_byte;
      end
    end
  end

  // Capture the first payload bytes
  always_ff @(posedge clk) begin
    for (int i = 0; i < HeadKeep; i++) begin
      if (in_fire && phase == PH_BODY && pay_pos < payload_length &&
          pay_pos == 8'(i)) begin
        payload_head[i] <= rx_byte;
      end
    end
  end

  // Stored record
  always_ff @(posedge clk) begin
    if (rst) begin
      rec <= '0;
    end else if (produce) begin
      rec <= rec_next;
    end
  end

  // Output register with skid: hold a result while the consumer stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (produce) begin
      if (!out_valid || out_fire) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_reg <= skid_reg;
      end
    end else if (produce) begin
      if (!out_valid || out_fire) begin
        out_reg <= result;
      end else begin
        skid_reg <= result;
      end
    end
  end

  // Drive the result ports
  assign command      = out_reg.command;
  assign gesture_num  = out_reg.rec.gesture_num;
  assign hand_x       = out_reg.rec.hand_x;
  assign hand_y       = out_reg.rec.hand_y;
  assign posture      = out_reg.rec.posture;
  assign emotion      = out_reg.rec.emotion;
  assign focus_phase  = out_reg.rec.focus_phase;
  assign guard_level  = out_reg.rec.guard_level;
  assign record_valid = out_reg.rec.valid;

endmodule

### tb/sv/xor_checked_frame_parser_tb.sv
`default_nettype none

module xor_checked_frame_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import xcfp_pkg::*;

  localparam int NumRegs      = int'(REG_CODE_SENTRY) + 1;
  localparam int HeadBytes    = FrameOverhead - 1;  // headers, length, command
  localparam int SettleCycles = 16;
  localparam int HoldCycles   = 300;
  localparam int PhaseBytes   = 140;
  localparam int RandPhases   = 4;
  localparam int PrintLimit   = 40;
  localparam int CycleLimit   = 400000;

  typedef enum logic [2:0] {
    ROW_GOOD,
    ROW_BAD_SUM,
    ROW_BAD_HEAD2,
    ROW_TOO_LONG,
    ROW_NOISE,
    ROW_SAME_CODES
  } row_kind_t;

  // Head holds payload bytes 0..4, byte 0 in the low bits
  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  len;
    logic [7:0]  cmd;
    logic [39:0] head;
    logic        pinned;
    result_t     want;
  } dir_row_t;

  // want = {command, gesture_num, hand_x, hand_y, posture, emotion, focus, guard, valid}
  localparam dir_row_t DirRows [16] = '{
    // unknown command, empty payload: record still at reset
    '{ROW_GOOD, 8'd0, 8'h00, 40'h0, 1'b1,
      {8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0}},
    // pomodoro sets its field but not the valid mark
    '{ROW_GOOD, 8'd1, 8'h04, 40'hFF, 1'b1,
      {8'h04, 8'h00, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b0}},
    '{ROW_GOOD, 8'd1, 8'h02, 40'h00, 1'b1,
      {8'h02, 8'h00, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b1}},
    // gesture with extreme coordinate bytes
    '{ROW_GOOD, 8'd5, 8'h01, 40'h00_FF_FF_00_FF, 1'b1,
      {8'h01, 8'hFF, 16'hFF00, 16'h00FF, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b1}},
    // short gesture and short posture leave the record alone
    '{ROW_GOOD, 8'd4, 8'h01, 40'h11_22_33_44_55, 1'b0, '0},
    '{ROW_GOOD, 8'd0, 8'h02, 40'h0, 1'b0, '0},
    '{ROW_GOOD, 8'd3, 8'h03, 40'h00_00_5A_C3_A5, 1'b0, '0},
    '{ROW_GOOD, 8'd1, 8'h05, 40'h7E, 1'b0, '0},
    '{ROW_BAD_SUM, 8'd1, 8'h02, 40'h33, 1'b0, '0},
    // mismatched second header, then a byte that would match it
    '{ROW_BAD_HEAD2, 8'd0, 8'hAA, 40'h0, 1'b0, '0},
    '{ROW_TOO_LONG, 8'hFF, 8'h00, 40'h0, 1'b0, '0},
    '{ROW_TOO_LONG, 8'(MaxFrameBytes - FrameOverhead + 1), 8'h00, 40'h0, 1'b0, '0},
    // longest frame that fits, unknown command
    '{ROW_GOOD, 8'(MaxFrameBytes - FrameOverhead), 8'hFF, 40'h01_02_03_04_05, 1'b0, '0},
    // all codes equal: gesture wins
    '{ROW_SAME_CODES, 8'd0, 8'h07, 40'h0, 1'b0, '0},
    '{ROW_GOOD, 8'd5, 8'h07, 40'h80_7F_01_FE_42, 1'b0, '0},
    '{ROW_GOOD, 8'd1, 8'h07, 40'h99, 1'b0, '0}
  };

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] rx_byte;
  logic       cfg_valid;
  logic       cfg_ready;
  reg_index_t cfg_index;
  logic [7:0] cfg_data;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] command;
  logic [7:0] gesture_num;
  logic [15:0] hand_x;
  logic [15:0] hand_y;
  logic [7:0] posture;
  logic [7:0] emotion;
  logic [7:0] focus_phase;
  logic [7:0] guard_level;
  logic       record_valid;

  xor_checked_frame_parser u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .command        (command),
    .gesture_num    (gesture_num),
    .hand_x         (hand_x),
    .hand_y         (hand_y),
    .posture        (posture),
    .emotion        (emotion),
    .focus_phase    (focus_phase),
    .guard_level    (guard_level),
    .record_valid   (record_valid)
  );

  // Parser state as seen by the checker
  logic [7:0] regs [NumRegs] = '{ResetHeaderFirst, ResetHeaderSecond, ResetCodeGesture,
                                 ResetCodePosture, ResetCodeEmotion, ResetCodePomodoro,
                                 ResetCodeSentry};
  phase_t     ph = PH_HEAD1;
  logic [8:0] frame_cnt = '0;
  logic [7:0] pay_len = '0;
  logic [7:0] cur_cmd = '0;
  logic [7:0] run_xor = '0;
  logic [7:0] head [HeadKeep] = '{default: '0};
  record_t    rec = '0;

  // Register values as last written by the stimulus side
  logic [7:0] tx_regs [NumRegs] = '{ResetHeaderFirst, ResetHeaderSecond, ResetCodeGesture,
                                    ResetCodePosture, ResetCodeEmotion, ResetCodePomodoro,
                                    ResetCodeSentry};

  result_t pending_records [$];
  // Typed-in expectation travels with the checksum byte of a directed row
  result_t pin_want = '0;
  logic    pin_now = 1'b0;
  bit      pin_next = 1'b0;
  result_t pin_next_want = '0;
  int      mismatches = 0;
  int      cycles = 0;
  int      bytes_sent = 0;
  bit      gaps_on = 1'b1;
  bit      stalls_on = 1'b1;
  bit      hold_req = 1'b0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < PrintLimit) $display("mismatch at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  function automatic void hunt_again();
    ph = PH_HEAD1;
    frame_cnt = '0;
    run_xor = '0;
  endfunction

  // Advance the parser by one byte; return 1 when a frame is accepted
  function automatic bit parse_byte(input logic [7:0] b, output result_t res);
    int pos;
    bit good;
    res = '0;
    case (ph)
      PH_HEAD1: begin
        if (b == regs[REG_HEADER_FIRST]) begin
          run_xor = b;
          frame_cnt = 9'd1;
          ph = PH_HEAD2;
        end
      end
      PH_HEAD2: begin
        if (b == regs[REG_HEADER_SECOND]) begin
          run_xor ^= b;
          frame_cnt = 9'd2;
          ph = PH_LEN;
        end else begin
          hunt_again();
        end
      end
      PH_LEN: begin
        if (int'(b) + FrameOverhead > MaxFrameBytes) begin
          hunt_again();
        end else begin
          pay_len = b;
          run_xor ^= b;
          frame_cnt = 9'd3;
          ph = PH_CMD;
        end
      end
      PH_CMD: begin
        cur_cmd = b;
        run_xor ^= b;
        frame_cnt = 9'd4;
        ph = PH_BODY;
      end
      PH_BODY: begin
        if (int'(frame_cnt) + 1 < int'(pay_len) + FrameOverhead) begin
          // payload byte: keep the head, fold into the checksum
          pos = int'(frame_cnt) - HeadBytes;
          if (pos < HeadKeep) head[pos] = b;
          run_xor ^= b;
          frame_cnt = frame_cnt + 9'd1;
        end else begin
          // checksum byte: update the record by the first matching code
          good = (b == run_xor);
          hunt_again();
          if (!good) return 1'b0;
          if (cur_cmd == regs[REG_CODE_GESTURE]) begin
            if (pay_len >= GestureNeed) begin
              rec.gesture_num = head[0];
              rec.hand_x = {head[2], head[1]};
              rec.hand_y = {head[4], head[3]};
              rec.valid = 1'b1;
            end
          end else if (cur_cmd == regs[REG_CODE_POSTURE]) begin
            if (pay_len >= 1) begin
              rec.posture = head[0];
              rec.valid = 1'b1;
            end
          end else if (cur_cmd == regs[REG_CODE_EMOTION]) begin
            if (pay_len >= 1) begin
              rec.emotion = head[0];
              rec.valid = 1'b1;
            end
          end else if (cur_cmd == regs[REG_CODE_POMODORO]) begin
            if (pay_len >= 1) rec.focus_phase = head[0];
          end else if (cur_cmd == regs[REG_CODE_SENTRY]) begin
            if (pay_len >= 1) begin
              rec.guard_level = head[0];
              rec.valid = 1'b1;
            end
          end
          res = {cur_cmd, rec};
          return 1'b1;
        end
      end
      default: hunt_again();
    endcase
    return 1'b0;
  endfunction

  // Monitor: predict on accepted bytes, track writes, check results
  always @(posedge clk) begin
    result_t nxt;
    result_t got;
    result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        if (parse_byte(rx_byte, nxt)) begin
          pending_records.push_back(nxt);
          if (pin_now && nxt !== pin_want) begin
            report_mismatch("directed row disagrees with prediction");
          end
        end else if (pin_now) begin
          report_mismatch("directed row produced no result");
        end
      end
      // A write takes effect from the next byte on
      if (cfg_valid && cfg_ready) regs[cfg_index] = cfg_data;
      if (out_valid && out_ready) begin
        got = {command, gesture_num, hand_x, hand_y, posture, emotion, focus_phase,
               guard_level, record_valid};
        if (pending_records.size() == 0) begin
          report_mismatch("result transaction with nothing pending");
        end else begin
          want = pending_records.pop_front();
          check_field("command", 16'(got.command), 16'(want.command));
          check_field("gesture_num", 16'(got.rec.gesture_num), 16'(want.rec.gesture_num));
          check_field("hand_x", got.rec.hand_x, want.rec.hand_x);
          check_field("hand_y", got.rec.hand_y, want.rec.hand_y);
          check_field("posture", 16'(got.rec.posture), 16'(want.rec.posture));
          check_field("emotion", 16'(got.rec.emotion), 16'(want.rec.emotion));
          check_field("focus_phase", 16'(got.rec.focus_phase),
                      16'(want.rec.focus_phase));
          check_field("guard_level", 16'(got.rec.guard_level), 16'(want.rec.guard_level));
          check_field("record_valid", 16'(got.rec.valid), 16'(want.rec.valid));
        end
      end
      cycles++;
      if (cycles > CycleLimit) begin
        $display("[xor_checked_frame_parser] ERROR");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else if (stalls_on && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one byte, with an optional idle burst ahead of it
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = (gaps_on && $urandom_range(0, 11) == 0) ? $urandom_range(1, 16) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // Drop valid and wait until every record is out and the block is quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_records.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_regs(input logic [7:0] vals [NumRegs]);
    for (int r = 0; r < NumRegs; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_index_t'(r);
      cfg_data <= vals[r];
      tx_regs[r] = vals[r];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // Send one frame, broken frame or run of noise
  task automatic send_unit(input row_kind_t kind, input logic [7:0] len,
                           input logic [7:0] cmd, input logic [39:0] head_bytes);
    logic [7:0] sum;
    logic [7:0] b;
    case (kind)
      ROW_NOISE: begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end
      ROW_BAD_HEAD2: begin
        send_byte(tx_regs[REG_HEADER_FIRST]);
        send_byte(cmd);
        send_byte(tx_regs[REG_HEADER_SECOND]);
      end
      ROW_TOO_LONG: begin
        send_byte(tx_regs[REG_HEADER_FIRST]);
        send_byte(tx_regs[REG_HEADER_SECOND]);
        send_byte(len);
      end
      default: begin
        sum = tx_regs[REG_HEADER_FIRST] ^ tx_regs[REG_HEADER_SECOND] ^ len ^ cmd;
        send_byte(tx_regs[REG_HEADER_FIRST]);
        send_byte(tx_regs[REG_HEADER_SECOND]);
        send_byte(len);
        send_byte(cmd);
        for (int i = 0; i < int'(len); i++) begin
          b = (i < HeadKeep) ? head_bytes[8*i +: 8] : 8'($urandom);
          sum ^= b;
          send_byte(b);
        end
        if (kind == ROW_BAD_SUM) sum ^= 8'($urandom_range(1, 255));
        // Tag the checksum byte with a typed-in expectation, if any
        pin_now <= pin_next;
        pin_want <= pin_next_want;
        send_byte(sum);
        pin_now <= 1'b0;
        pin_next = 1'b0;
      end
    endcase
  endtask

  // Stimulus
  initial begin
    logic [7:0] vals [NumRegs];
    logic [7:0] len;
    logic [7:0] cmd;
    row_kind_t  kind;
    int         pick;
    int         phase_end;

    rst <= 1'b1;
    in_valid <= 1'b0;
    rx_byte <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_HEADER_FIRST;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed rows at reset settings, until the equal-codes row rewrites the codes
    for (int i = 0; i < $size(DirRows); i++) begin
      if (DirRows[i].kind == ROW_SAME_CODES) begin
        vals = tx_regs;
        for (int r = int'(REG_CODE_GESTURE); r < NumRegs; r++) vals[r] = DirRows[i].cmd;
        settle();
        write_regs(vals);
      end else begin
        if (DirRows[i].pinned) begin
          pin_next = 1'b1;
          pin_next_want = DirRows[i].want;
        end
        send_unit(DirRows[i].kind, DirRows[i].len, DirRows[i].cmd, DirRows[i].head);
      end
    end

    // Random phases, each under its own register setting
    for (int p = 0; p < RandPhases; p++) begin
      case (p)
        0: vals = '{ResetHeaderFirst, ResetHeaderSecond, ResetCodeGesture, ResetCodePosture,
                    ResetCodeEmotion, ResetCodePomodoro, ResetCodeSentry};
        1: vals = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01};
        2: begin
          vals = '{8'hFF, 8'h00, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom)};
          vals[REG_CODE_SENTRY] = vals[REG_CODE_POSTURE];
        end
        default: vals = '{8'($urandom), 8'($urandom), 8'($urandom_range(0, 7)),
                          8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)),
                          8'($urandom_range(0, 7)), 8'($urandom_range(0, 7))};
      endcase
      settle();
      write_regs(vals);
      if (p == 0) hold_req = 1'b1;
      if (p == RandPhases - 1) begin
        gaps_on = 1'b0;
        stalls_on = 1'b0;
      end
      phase_end = bytes_sent + PhaseBytes;
      while (bytes_sent < phase_end) begin
        pick = $urandom_range(0, 5);
        cmd = (pick < 5) ? tx_regs[int'(REG_CODE_GESTURE) + pick] : 8'($urandom);
        pick = $urandom_range(0, 99);
        len = (pick < 60) ? 8'($urandom_range(0, 6)) :
              (pick < 90) ? 8'($urandom_range(7, 20)) :
              8'($urandom_range(21, MaxFrameBytes - FrameOverhead));
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          kind = ROW_GOOD;
        end else if (pick < 80) begin
          kind = ROW_BAD_SUM;
        end else if (pick < 88) begin
          kind = ROW_NOISE;
        end else if (pick < 94) begin
          kind = ROW_BAD_HEAD2;
          cmd = tx_regs[REG_HEADER_SECOND] ^ 8'($urandom_range(1, 255));
        end else begin
          kind = ROW_TOO_LONG;
          len = 8'($urandom_range(MaxFrameBytes - FrameOverhead + 1, 255));
        end
        send_unit(kind, len, cmd, {$urandom, 8'($urandom)});
      end
    end

    // Drain and finish
    settle();
    if (mismatches == 0) begin
      $display("[xor_checked_frame_parser] OK");
    end else begin
      $display("[xor_checked_frame_parser] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
rtl/core/xcfp_pkg.sv
rtl/core/xor_checked_frame_parser.sv
tb/sv/xor_checked_frame_parser_tb.sv
